>>> rtl/ks_voice_pkg.sv
// Shared constants, codes and controller/datapath bundles for the plucked-string voice.
// No dependencies; every other file imports this package.
package ks_voice_pkg;

   localparam int MAX_LENGTH  = 512;
   localparam int LINE_ADDR_W = $clog2(MAX_LENGTH);

   localparam int MODE_W   = 2;
   localparam int LEN_W    = 10;
   localparam int MAG_W    = 16;
   localparam int SAMPLE_W = 16;
   localparam int GAIN_W   = 16;
   localparam int SEED_W   = 31;
   localparam int CLAMP_W  = (LINE_ADDR_W + 1 > LEN_W) ? LINE_ADDR_W + 1 : LEN_W;

   localparam logic [14:0]         PM_MULT     = 15'd16807;
   localparam logic [SEED_W-1:0]   SEED_RESET  = SEED_W'(1);
   localparam logic [GAIN_W-1:0]   GAIN_RESET  = 16'd32686;

   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_TICK     = 2'd0;
   localparam mode_type MODE_NOTE_ON  = 2'd1;
   localparam mode_type MODE_NOTE_OFF = 2'd2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_DECAY_GAIN = 1'b0;

   // Controller -> datapath commands
   typedef struct packed {
      logic note_on;     // latch length, magnitude, rewind position
      logic fill_start;  // rewind fill index
      logic seed_mul;    // partial products of the seed
      logic seed_fold;   // fold products mod 2^31-1 into the seed
      logic fill_write;  // write one noise entry, step fill index
      logic line_read;   // read current and previous entries
      logic filt_mul;    // tap sum times gain
      logic write_back;  // write filtered value, load response, advance position
      logic emit_zero;   // load a zero response
   } ks_cmd_type;

   // Datapath -> controller status
   typedef struct packed {
      logic fill_last;
      logic out_free;
   } ks_stat_type;

endpackage

>>> rtl/ks_voice_if.sv
// Request and response channel interfaces of the plucked-string voice.
// Depends on ks_voice_pkg for field widths.
interface ks_voice_req_if;
   import ks_voice_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [MODE_W-1:0]     mode;
   logic [LEN_W-1:0]      delay_length;
   logic [MAG_W-1:0]      magnitude;

   modport source (output valid, mode, delay_length, magnitude, input ready);
   modport sink   (input valid, mode, delay_length, magnitude, output ready);
endinterface

interface ks_voice_rsp_if;
   import ks_voice_pkg::*;
   logic                        valid;
   logic                        ready;
   logic signed [SAMPLE_W-1:0]  sample;

   modport source (output valid, sample, input ready);
   modport sink   (input valid, sample, output ready);
endinterface

>>> rtl/karplus_strong_string_voice.sv
// Plucked-string voice top level: CSR port, controller and datapath.
// Sounding tick: read, multiply, then write-back into the output register once it is free.
// First tick after note-on adds a noise fill: seed multiply, fold and write for each entry.
// Silent tick: a zero response; note-on, note-off and unused codes: no response.
// Synchronous active-high reset: voice silent, seed 1, decay gain 32686; line contents undefined.
module karplus_strong_string_voice (
   input  logic                                   clock,
   input  logic                                   reset,
   ks_voice_req_if.sink                           req_ch,
   ks_voice_rsp_if.source                         rsp_ch,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [ks_voice_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ks_voice_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ks_voice_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);
   import ks_voice_pkg::*;

   ks_cmd_type              cmd;
   ks_stat_type             stat;
   logic [GAIN_W-1:0]       gain_ff;
   logic                    csr_write;
   logic [CSR_ADDR_W-3:0]   csr_index;
   logic                    req_ready;
   logic                    rsp_valid;
   logic signed [SAMPLE_W-1:0] rsp_sample;

   // ---------------------------------------------------------------
   // CSR: one register, decay gain. Word index comes from paddr[2];
   // byte offset bits are ignored. Zero wait states.
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_prdata = (csr_index == CSR_IDX_DECAY_GAIN) ? CSR_DATA_W'(gain_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;
      end else if (csr_write && (csr_index == CSR_IDX_DECAY_GAIN)) begin
         gain_ff <= csr_pwdata[GAIN_W-1:0];
      end
   end

   // ---------------------------------------------------------------
   // Controller: takes requests only when idle; sequences the noise
   // fill (armed voice) and the read / multiply / write-back steps
   // of a sounding tick. Results leave through the datapath's output register,
   // so a new request is taken while a response still waits.
   // ---------------------------------------------------------------
   ks_voice_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_ch.valid),
      .req_mode     (req_ch.mode),
      .req_mag_zero (req_ch.magnitude == '0),
      .req_ready    (req_ready),
      .stat         (stat),
      .cmd          (cmd)
   );

   // ---------------------------------------------------------------
   // Datapath: 512-entry line memory (one write, two registered reads),
   // 31-bit minimal-standard noise seed, loop filter
   // floor((cur + prev) * gain / 65536) with saturation.
   // ---------------------------------------------------------------
   ks_voice_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_delay_length (req_ch.delay_length),
      .req_magnitude    (req_ch.magnitude),
      .decay_gain       (gain_ff),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_valid),
      .rsp_sample       (rsp_sample),
      .stat             (stat)
   );

   assign req_ch.ready  = req_ready;
   assign rsp_ch.valid  = rsp_valid;
   assign rsp_ch.sample = rsp_sample;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // note and unused transactions never produce a response
   a_no_rsp_for_note: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.mode != MODE_TICK))
      |=> !(cmd.write_back || cmd.emit_zero))
      else $error("response loaded after a non-tick transaction");

   // output register loaded only when it is empty or being drained
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.write_back || cmd.emit_zero) |-> (!rsp_ch.valid || rsp_ch.ready))
      else $error("response register overwritten");

   // requests are taken only while no line operation is in flight
   a_accept_when_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready)
      |-> !(cmd.fill_write || cmd.write_back || cmd.line_read || cmd.seed_mul))
      else $error("request accepted during line operation");

endmodule

>>> rtl/ks_voice_dp.sv
// Datapath: delay line memory, noise generator, loop filter and response register.
// Depends on ks_voice_pkg; driven by ks_voice_ctrl commands.
module ks_voice_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ks_voice_pkg::ks_cmd_type             cmd,
   input  logic [ks_voice_pkg::LEN_W-1:0]       req_delay_length,
   input  logic [ks_voice_pkg::MAG_W-1:0]       req_magnitude,
   input  logic [ks_voice_pkg::GAIN_W-1:0]      decay_gain,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [ks_voice_pkg::SAMPLE_W-1:0] rsp_sample,
   output ks_voice_pkg::ks_stat_type            stat
);
   import ks_voice_pkg::*;

   logic [SAMPLE_W-1:0]        line_mem [MAX_LENGTH];

   logic [LINE_ADDR_W-1:0]     pos_ff, pos_in;
   logic [LINE_ADDR_W-1:0]     len_m1_ff, len_m1_in;
   logic [LINE_ADDR_W-1:0]     fill_idx_ff;
   logic [MAG_W-1:0]           mag_ff;
   logic [SEED_W-1:0]          seed_ff;
   logic [29:0]                hi_ff;
   logic [30:0]                lo_ff;
   logic signed [SAMPLE_W-1:0] cur_ff, prev_ff;
   logic signed [33:0]         acc_ff;
   logic                       rsp_valid_ff;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;

   logic [CLAMP_W-1:0]         len_ext;
   logic [LINE_ADDR_W-1:0]     prev_addr;
   logic [31:0]                fold_sum, fold_wrap;
   logic signed [32:0]         noise_prod;
   logic [SAMPLE_W-1:0]        noise_word;
   logic signed [16:0]         tap_sum;
   logic signed [17:0]         filt_q;
   logic signed [SAMPLE_W-1:0] filt_sat;
   logic                       mem_we;
   logic [LINE_ADDR_W-1:0]     mem_waddr;
   logic [SAMPLE_W-1:0]        mem_wdata;

   // note-on length: zero -> 1, long -> MAX_LENGTH; kept as length-1
   always_comb begin
      len_ext = CLAMP_W'(req_delay_length);
      if (len_ext == '0) begin
         len_m1_in = '0;
      end else if (len_ext > CLAMP_W'(MAX_LENGTH)) begin
         len_m1_in = LINE_ADDR_W'(MAX_LENGTH - 1);
      end else begin
         len_m1_in = LINE_ADDR_W'(len_ext - CLAMP_W'(1));
      end
   end

   assign prev_addr = (pos_ff == '0) ? len_m1_ff : pos_ff - LINE_ADDR_W'(1);
   assign pos_in    = (pos_ff == len_m1_ff) ? '0 : pos_ff + LINE_ADDR_W'(1);

   // Park-Miller fold, same carry behavior as the 32-bit split form
   always_comb begin
      fold_sum  = {1'b0, lo_ff} + {1'b0, hi_ff[14:0], 16'd0} + 32'(hi_ff[29:15]);
      fold_wrap = {1'b0, fold_sum[30:0]} + 32'(fold_sum[31]);
   end

   assign noise_prod = 33'($signed({1'b0, mag_ff})) * 33'($signed(seed_ff[15:0]));
   assign noise_word = noise_prod[31:16];

   assign tap_sum = 17'(cur_ff) + 17'(prev_ff);
   assign filt_q  = acc_ff[33:16];

   always_comb begin
      if (filt_q > 18'sd32767) begin
         filt_sat = 16'sh7FFF;
      end else if (filt_q < -18'sd32768) begin
         filt_sat = 16'sh8000;
      end else begin
         filt_sat = filt_q[15:0];
      end
   end

   assign mem_we    = cmd.fill_write | cmd.write_back;
   assign mem_waddr = cmd.fill_write ? fill_idx_ff : pos_ff;
   assign mem_wdata = cmd.fill_write ? noise_word : filt_sat;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.line_read) begin
         cur_ff  <= line_mem[pos_ff];
         prev_ff <= line_mem[prev_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         len_m1_ff   <= '0;
         fill_idx_ff <= '0;
         mag_ff      <= '0;
         seed_ff     <= SEED_RESET;
      end else begin
         if (cmd.note_on) begin
            pos_ff    <= '0;
            len_m1_ff <= len_m1_in;
            mag_ff    <= req_magnitude;
         end else if (cmd.write_back) begin
            pos_ff <= pos_in;
         end
         if (cmd.fill_start) begin
            fill_idx_ff <= '0;
         end else if (cmd.fill_write) begin
            fill_idx_ff <= fill_idx_ff + LINE_ADDR_W'(1);
         end
         if (cmd.seed_fold) begin
            seed_ff <= fold_wrap[30:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.seed_mul) begin
         hi_ff <= 30'(PM_MULT) * 30'(seed_ff[30:16]);
         lo_ff <= 31'(PM_MULT) * 31'(seed_ff[15:0]);
      end
      if (cmd.filt_mul) begin
         acc_ff <= 34'(tap_sum) * 34'($signed({1'b0, decay_gain}));
      end
      if (cmd.write_back) begin
         rsp_sample_ff <= filt_sat;
      end else if (cmd.emit_zero) begin
         rsp_sample_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.write_back || cmd.emit_zero) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample     = rsp_sample_ff;
   assign stat.fill_last = (fill_idx_ff == len_m1_ff);
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;

endmodule

>>> rtl/ks_voice_ctrl.sv
// Controller: request decode, voice phase and sequencing of fill and tick steps.
// Depends on ks_voice_pkg; drives ks_voice_dp through ks_cmd_type.
module ks_voice_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [ks_voice_pkg::MODE_W-1:0]   req_mode,
   input  logic                              req_mag_zero,
   output logic                              req_ready,
   input  ks_voice_pkg::ks_stat_type         stat,
   output ks_voice_pkg::ks_cmd_type          cmd
);
   import ks_voice_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FMUL  = 3'd1;
   localparam logic [2:0] ST_FFOLD = 3'd2;
   localparam logic [2:0] ST_FWR   = 3'd3;
   localparam logic [2:0] ST_RD    = 3'd4;
   localparam logic [2:0] ST_MUL   = 3'd5;
   localparam logic [2:0] ST_WB    = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_ARMED = 2'd1;
   localparam logic [1:0] PH_SOUND = 2'd2;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_NOTE_ON: begin
                     if (req_mag_zero) begin
                        phase_in = PH_IDLE;
                     end else begin
                        cmd.note_on = 1'b1;
                        phase_in    = PH_ARMED;
                     end
                  end
                  MODE_NOTE_OFF: begin
                     phase_in = PH_IDLE;
                  end
                  MODE_TICK: begin
                     if (phase_ff == PH_ARMED) begin
                        cmd.fill_start = 1'b1;
                        state_in       = ST_FMUL;
                     end else if (phase_ff == PH_SOUND) begin
                        state_in = ST_RD;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FMUL: begin
            cmd.seed_mul = 1'b1;
            state_in     = ST_FFOLD;
         end
         ST_FFOLD: begin
            cmd.seed_fold = 1'b1;
            state_in      = ST_FWR;
         end
         ST_FWR: begin
            cmd.fill_write = 1'b1;
            if (stat.fill_last) begin
               phase_in = PH_SOUND;
               state_in = ST_RD;
            end else begin
               state_in = ST_FMUL;
            end
         end
         ST_RD: begin
            cmd.line_read = 1'b1;
            state_in      = ST_MUL;
         end
         ST_MUL: begin
            cmd.filt_mul = 1'b1;
            state_in     = ST_WB;
         end
         ST_WB: begin
            if (stat.out_free) begin
               cmd.write_back = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit_zero = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

>>> tb/ks_voice_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the plucked-string voice: predicts the sample stream and checks it.
// Depends on ks_voice_pkg for widths, mode codes and reset constants.
package ks_voice_sb_pkg;
   import ks_voice_pkg::*;

   localparam mode_type MODE_UNUSED  = 2'd3;
   localparam longint   SEED_MODULUS = 64'h7FFF_FFFF;

   typedef enum logic [1:0] {VOICE_IDLE, VOICE_ARMED, VOICE_SOUNDING} voice_phase_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

   class ks_string_scoreboard;
      voice_phase_type   phase;
      sample_type        delay_taps [MAX_LENGTH];
      int                line_len;
      int                rd_pos;
      logic [SEED_W-1:0] seed;
      logic [MAG_W-1:0]  note_mag;
      logic [GAIN_W-1:0] gain;
      sample_type        expected_samples [$];
      int                errors;
      int                samples_checked;
      int                note_ons;

      function new();
         phase           = VOICE_IDLE;
         line_len        = 0;
         rd_pos          = 0;
         seed            = SEED_RESET;
         note_mag        = '0;
         gain            = GAIN_RESET;
         errors          = 0;
         samples_checked = 0;
         note_ons        = 0;
      endfunction

      function void set_gain(logic [GAIN_W-1:0] g);
         gain = g;
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      // minimal-standard generator, s * 16807 mod (2^31 - 1)
      function logic [SEED_W-1:0] park_miller(logic [SEED_W-1:0] s);
         longint prod;
         prod = longint'(s) * longint'(PM_MULT);
         return SEED_W'(prod % SEED_MODULUS);
      endfunction

      function void pluck_fill();
         logic [SEED_W-1:0] s;
         sample_type        r;
         longint            p;
         s = seed;
         for (int i = 0; i < line_len; i++) begin
            s = park_miller(s);
            r = $signed(s[15:0]);
            p = longint'(note_mag) * longint'(r);
            delay_taps[i] = SAMPLE_W'(p >>> 16);
         end
         seed = s;
      endfunction

      function sample_type advance_string();
         int     pos;
         int     prev;
         longint acc;
         if (phase == VOICE_IDLE || line_len == 0)
            return '0;
         if (phase == VOICE_ARMED) begin
            pluck_fill();
            phase = VOICE_SOUNDING;
         end
         pos = (rd_pos >= line_len) ? 0 : rd_pos;
         prev = (pos > 0) ? pos - 1 : line_len - 1;
         acc = (longint'(delay_taps[pos]) + longint'(delay_taps[prev])) * longint'(gain);
         acc = acc >>> 16;
         if (acc > 32767)
            acc = 32767;
         else if (acc < -32768)
            acc = -32768;
         delay_taps[pos] = SAMPLE_W'(acc);
         pos++;
         rd_pos = (pos >= line_len) ? 0 : pos;
         return SAMPLE_W'(acc);
      endfunction

      function void note_request(mode_type mode, logic [LEN_W-1:0] len, logic [MAG_W-1:0] mag);
         int n;
         case (mode)
            MODE_NOTE_ON: begin
               note_ons++;
               if (mag == '0) begin
                  phase = VOICE_IDLE;
               end else begin
                  n = int'(len);
                  if (n > MAX_LENGTH)
                     n = MAX_LENGTH;
                  if (n == 0)
                     n = 1;
                  line_len = n;
                  rd_pos   = 0;
                  note_mag = mag;
                  phase    = VOICE_ARMED;
               end
            end
            MODE_NOTE_OFF: phase = VOICE_IDLE;
            MODE_TICK:     expected_samples.push_back(advance_string());
            default: ;
         endcase
      endfunction

      function void check_sample(sample_type got);
         sample_type exp_sample;
         if (expected_samples.size() == 0) begin
            $error("sample: no result expected, actual %0d", got);
            errors++;
            return;
         end
         exp_sample = expected_samples.pop_front();
         samples_checked++;
         if (got !== exp_sample) begin
            $error("sample mismatch: expected %0d, actual %0d", exp_sample, got);
            errors++;
         end
      endfunction
   endclass

endpackage

>>> tb/tb_karplus_strong_string_voice.sv
`timescale 1ns / 100ps
// Top-level testbench of the plucked-string voice: clock, reset, drivers and CSR tasks.
// Depends on ks_voice_pkg, the channel interfaces and ks_voice_sb_pkg.
module tb_karplus_strong_string_voice;
   import ks_voice_pkg::*;
   import ks_voice_sb_pkg::*;

   localparam int ITEM_TARGET   = 1500;
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 16;         // note-on/off leave no result, give them time
   localparam int MAX_WAIT      = 17;
   localparam int PHASE_ITEMS   = 100;
   localparam logic [CSR_ADDR_W-1:0] GAIN_ADDR = {CSR_IDX_DECAY_GAIN, 2'b00};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   ks_voice_req_if req_ch ();
   ks_voice_rsp_if rsp_ch ();

   ks_string_scoreboard sb;

   bit steady      = 1'b0;   // set: both sides run back to back for a phase
   int items_sent  = 0;      // transactions that the voice acts on (unused code excluded)
   int cycle_count = 0;
   int csr_errors  = 0;

   karplus_strong_string_voice dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout: run stuck after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Per-transaction wait; a quarter of the draws are forced to zero so bursts happen.
   function automatic int draw_wait();
      if (steady || $urandom_range(0, 3) == 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // Mostly short strings so the fill stays cheap; a few clamp at the line size.
   function automatic logic [LEN_W-1:0] draw_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return LEN_W'($urandom_range(1, 24));
      if (r < 88)
         return LEN_W'($urandom_range(25, 128));
      if (r < 97)
         return LEN_W'($urandom_range(129, 1023));
      return '0;
   endfunction

   function automatic logic [MAG_W-1:0] draw_magnitude();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return '1;
      if (r < 20)
         return MAG_W'($urandom_range(1, 255));
      return MAG_W'($urandom_range(1, 65535));
   endfunction

   // Extremes first, then mostly musical gains with an occasional wild one.
   function automatic logic [GAIN_W-1:0] draw_gain(int phase_idx);
      int r;
      case (phase_idx)
         0: return 16'd32768;
         1: return 16'd0;
         2: return 16'hFFFF;   // above unity: the filter saturates
         3: return 16'd1;
         4: return GAIN_RESET;
         default: begin
            r = $urandom_range(0, 99);
            if (r < 75)
               return GAIN_W'($urandom_range(30000, 32768));
            if (r < 90)
               return GAIN_W'($urandom_range(0, 65535));
            if (r < 95)
               return 16'hFFFF;
            return 16'd32768;
         end
      endcase
   endfunction

   // One request transaction: optional idle gap, then hold valid until ready.
   // valid is only lowered in gap cycles, so back-to-back items keep it high.
   task automatic send_item(mode_type mode, logic [LEN_W-1:0] len, logic [MAG_W-1:0] mag);
      int gap;
      gap = draw_wait();
      repeat (gap) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= mode;
      req_ch.delay_length <= len;
      req_ch.magnitude    <= mag;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sb.note_request(mode, len, mag);
      if (mode != MODE_UNUSED)
         items_sent++;
   endtask

   // Block goes idle: every sample back, plus slack for a trailing note-on/off.
   task automatic quiesce();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write of decay_gain, then a read back of the same register.
   task automatic program_gain(logic [GAIN_W-1:0] g);
      logic [CSR_DATA_W-1:0] rd;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= GAIN_ADDR;
      csr_pwdata  <= CSR_DATA_W'(g);
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.set_gain(g);
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rd = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (rd[GAIN_W-1:0] !== g) begin
         $error("decay_gain readback: expected %0d, actual %0d", g, rd[GAIN_W-1:0]);
         csr_errors++;
      end
   endtask

   // A pluck followed by a run of ticks, salted with note-off, re-arm and unused codes.
   // Tick payload fields are don't-care, so they carry random bits.
   task automatic play_phrase();
      int ticks;
      int r;
      send_item(MODE_NOTE_ON, draw_length(), draw_magnitude());
      ticks = $urandom_range(1, 40);
      for (int k = 0; k < ticks; k++) begin
         r = $urandom_range(0, 99);
         if (r < 88)
            send_item(MODE_TICK, LEN_W'($urandom), MAG_W'($urandom));
         else if (r < 91)
            send_item(MODE_NOTE_OFF, LEN_W'($urandom), MAG_W'($urandom));
         else if (r < 94)
            send_item(MODE_UNUSED, LEN_W'($urandom), MAG_W'($urandom));
         else if (r < 97)
            send_item(MODE_NOTE_ON, draw_length(), draw_magnitude());
         else
            send_item(MODE_NOTE_ON, LEN_W'($urandom), '0);
      end
   endtask

   // Result side: random stall before each sample, then accept and check.
   initial begin
      int stall;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = draw_wait();
         repeat (stall) begin
            @(negedge clock);
            rsp_ch.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         sb.check_sample(rsp_ch.sample);
      end
   end

   // Stimulus: reset, directed corner cases, then gain phases of random phrases.
   initial begin
      int phase_idx;
      int phase_start;
      sb = new();
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_TICK;
      req_ch.delay_length = '0;
      req_ch.magnitude    = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset gain
      send_item(MODE_TICK, '0, '0);                 // silent voice -> 0
      send_item(MODE_UNUSED, '1, '1);               // ignored, no result
      send_item(MODE_NOTE_ON, '0, 16'hFFFF);        // zero length -> one-entry line
      repeat (3) send_item(MODE_TICK, '0, '0);
      send_item(MODE_NOTE_ON, 10'd1023, 16'd1);     // clamped to the full line
      repeat (2) send_item(MODE_TICK, '1, '1);
      send_item(MODE_NOTE_ON, 10'd8, 16'h8000);
      repeat (2) send_item(MODE_TICK, '0, '0);
      send_item(MODE_NOTE_ON, 10'd5, 16'hFFFF);     // re-arm while sounding
      repeat (2) send_item(MODE_TICK, '0, '0);
      send_item(MODE_NOTE_ON, 10'd7, '0);           // zero magnitude acts as note-off
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_NOTE_ON, 10'd3, 16'h7FFF);
      send_item(MODE_TICK, '0, '0);
      send_item(MODE_NOTE_OFF, '0, '0);
      send_item(MODE_TICK, '0, '0);

      // random part: each phase reprograms the gain while idle
      phase_idx = 0;
      while (items_sent < ITEM_TARGET) begin
         quiesce();
         program_gain(draw_gain(phase_idx));
         steady = (phase_idx % 4 == 3);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            play_phrase();
         phase_idx++;
      end
      steady = 1'b0;
      quiesce();

      $display("Summary: %0d transactions (%0d note-ons), %0d samples checked",
               items_sent, sb.note_ons, sb.samples_checked);
      $display("Summary: %0d gain phases incl. 0, 1, 32768, 65535 and reset gain, %0d cycles",
               phase_idx, cycle_count);
      if (sb.errors == 0 && csr_errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
rtl/ks_voice_pkg.sv
rtl/ks_voice_if.sv
rtl/ks_voice_dp.sv
rtl/ks_voice_ctrl.sv
rtl/karplus_strong_string_voice.sv
tb/ks_voice_sb_pkg.sv
tb/tb_karplus_strong_string_voice.sv
